>>> rtl/sdp_pkg.sv
// Shared constants and request codes for the step/direction pulse generator.
`default_nettype none

package sdp_pkg;

  localparam int POSITION_BITS_DEF = 24;
  localparam int DATA_W            = 32;
  localparam int ADDR_W            = 3;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_MOVE = 2'd1,
    REQ_HALT = 2'd2
  } req_t;

  typedef enum logic {
    REG_ABS_MODE = 1'b0,
    REG_MAX_POS  = 1'b1
  } reg_idx_t;

endpackage

`default_nettype wire

>>> rtl/sdp_if.sv
// Request and result channel interfaces for the step/direction pulse generator.
`default_nettype none

interface sdp_in_if #(
  parameter int POSITION_BITS = sdp_pkg::POSITION_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic signed [POSITION_BITS:0] move_value;

  modport source (output valid, output req_type, output move_value, input ready);
  modport sink   (input valid, input req_type, input move_value, output ready);
endinterface

interface sdp_out_if #(
  parameter int POSITION_BITS = sdp_pkg::POSITION_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic                     step_level;
  logic                     direction;
  logic                     busy_res;
  logic                     done_res;
  logic [POSITION_BITS-1:0] position;

  modport source (output valid, output step_level, output direction, output busy_res,
                  output done_res, output position, input ready);
  modport sink   (input valid, input step_level, input direction, input busy_res,
                  input done_res, input position, output ready);
endinterface

`default_nettype wire

>>> rtl/step_dir_pulse_generator.sv
// Step/direction pulse generator: motion state, result register and APB register port.
// Each result is registered straight from its request transfer.
// Throughput: one request per cycle while out_ch is not stalled; the state update
// is one compare and increment/decrement pass on the position and target registers.
// The result register frees itself when its transfer completes, so a new
// request is taken in the same cycle as the old result leaves.
// Reset (rst_n low, synchronous): motion state cleared, absolute mode on, limit all ones.
`default_nettype none

module step_dir_pulse_generator #(
  parameter int POSITION_BITS = sdp_pkg::POSITION_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  sdp_in_if.sink                           in_ch,
  sdp_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sdp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [sdp_pkg::DATA_W-1:0]  pwdata,
  output logic      [sdp_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);
  import sdp_pkg::*;

  localparam int PW = POSITION_BITS;
  localparam logic signed [PW:0] MV_ONE = (PW+1)'(1);

  logic                   abs_mode_r;
  logic [PW-1:0]          max_pos_r;
  logic [PW-1:0]          pos_r, pos_nxt;
  logic signed [PW:0]     tor_r, tor_nxt;
  logic                   phase_r, phase_nxt;
  logic                   halt_r, halt_nxt;
  logic                   running_r, running_nxt;
  logic                   step_r, step_nxt;
  logic                   dir_r, dir_nxt;
  logic                   done_nxt;
  logic                   out_valid_r;
  logic                   out_step_r, out_dir_r, out_busy_r, out_done_r;
  logic [PW-1:0]          out_pos_r;
  logic                   in_xfer;
  logic                   cfg_wr;
  logic signed [PW:0]     pos_ext;
  logic                   stepped;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign pos_ext     = signed'({1'b0, pos_r});

  always_comb begin
    prdata = '0;
    case (reg_idx_t'(paddr[2]))
      REG_ABS_MODE: prdata = DATA_W'(abs_mode_r);
      REG_MAX_POS:  prdata = DATA_W'(max_pos_r);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    pos_nxt     = pos_r;
    tor_nxt     = tor_r;
    phase_nxt   = phase_r;
    halt_nxt    = halt_r;
    running_nxt = running_r;
    step_nxt    = step_r;
    dir_nxt     = dir_r;
    done_nxt    = 1'b0;
    stepped     = 1'b0;
    case (in_ch.req_type)
      REQ_TICK: begin
        if (running_r) begin
          if (abs_mode_r) begin
            if (tor_r > pos_ext) begin
              if (max_pos_r > pos_r) begin
                dir_nxt   = 1'b0;
                phase_nxt = !phase_r;
                step_nxt  = !phase_r;
                stepped   = phase_r;
                if (stepped) begin
                  pos_nxt = pos_r + PW'(1);
                  if (halt_r) begin
                    halt_nxt = 1'b0;
                    tor_nxt  = signed'({1'b0, pos_nxt});
                  end
                end
              end else begin
                tor_nxt = pos_ext;
              end
            end else if (tor_r < pos_ext) begin
              if (pos_r != '0) begin
                dir_nxt   = 1'b1;
                phase_nxt = !phase_r;
                step_nxt  = !phase_r;
                stepped   = phase_r;
                if (stepped) begin
                  pos_nxt = pos_r - PW'(1);
                  if (halt_r) begin
                    halt_nxt = 1'b0;
                    tor_nxt  = signed'({1'b0, pos_nxt});
                  end
                end
              end else begin
                tor_nxt = pos_ext;
              end
            end else begin
              running_nxt = 1'b0;
              halt_nxt    = 1'b0;
              done_nxt    = 1'b1;
            end
          end else begin
            if (tor_r != '0) begin
              dir_nxt   = tor_r[PW];
              phase_nxt = !phase_r;
              step_nxt  = !phase_r;
              stepped   = phase_r;
              if (stepped) begin
                tor_nxt = tor_r[PW] ? (tor_r + MV_ONE) : (tor_r - MV_ONE);
                if (halt_r) begin
                  halt_nxt = 1'b0;
                  tor_nxt  = '0;
                end
              end
            end else begin
              running_nxt = 1'b0;
              halt_nxt    = 1'b0;
              done_nxt    = 1'b1;
            end
          end
        end
      end
      REQ_MOVE: begin
        tor_nxt     = in_ch.move_value;
        running_nxt = 1'b1;
        halt_nxt    = 1'b0;
      end
      REQ_HALT: begin
        if (running_r) begin
          halt_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_mode_r  <= 1'b1;
      max_pos_r   <= '1;
      pos_r       <= '0;
      tor_r       <= '0;
      phase_r     <= 1'b0;
      halt_r      <= 1'b0;
      running_r   <= 1'b0;
      step_r      <= 1'b0;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx_t'(paddr[2]))
          REG_ABS_MODE: abs_mode_r <= pwdata[0];
          REG_MAX_POS:  max_pos_r  <= pwdata[PW-1:0];
          default: begin
          end
        endcase
      end
      if (in_xfer) begin
        pos_r       <= pos_nxt;
        tor_r       <= tor_nxt;
        phase_r     <= phase_nxt;
        halt_r      <= halt_nxt;
        running_r   <= running_nxt;
        step_r      <= step_nxt;
        dir_r       <= dir_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_step_r <= step_nxt;
      out_dir_r  <= dir_nxt;
      out_busy_r <= running_nxt;
      out_done_r <= done_nxt;
      out_pos_r  <= pos_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.step_level = out_step_r;
  assign out_ch.direction  = out_dir_r;
  assign out_ch.busy_res   = out_busy_r;
  assign out_ch.done_res   = out_done_r;
  assign out_ch.position   = out_pos_r;

  a_step_follows_phase: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == phase_r)
    else $error("step line out of step with pulse phase");

  a_halt_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> running_r)
    else $error("halt latched while idle");

  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && done_nxt |=> !running_r && !halt_r)
    else $error("done reported while still running");

  a_phase_only_running: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !running_r && !running_nxt |=> phase_r == $past(phase_r))
    else $error("pulse phase moved while idle");

endmodule

`default_nettype wire
